// ===== rtl/vfcm_pkg.sv =====
// ----------------------------------------------------------------------------
// vfcm_pkg: shared types and tables for the voxel face cull mesher
// grid size, sequencer states, face and layer codes and the corner table
// ----------------------------------------------------------------------------
package vfcm_pkg;

  localparam int GRID_X = 16;
  localparam int GRID_Y = 16;
  localparam int GRID_Z = 16;

  localparam int COORD_W = 4;
  localparam int CELLS   = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W  = $clog2(CELLS);

  localparam logic [COORD_W-1:0] X_MAX = COORD_W'(GRID_X - 1);
  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(GRID_Y - 1);
  localparam logic [COORD_W-1:0] Z_MAX = COORD_W'(GRID_Z - 1);
  localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(CELLS - 1);

  // item kinds carried on in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MESH  = 1'b1;

  // face codes in emission order
  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  localparam int NUM_FACES   = 6;
  localparam int NUM_CORNERS = 6;
  localparam logic [2:0] CORNER_LAST = 3'(NUM_CORNERS - 1);
  localparam logic [2:0] PROBE_LAST  = 3'(NUM_FACES);

  // texture layers
  localparam logic [1:0] LAYER_TOP    = 2'd0;
  localparam logic [1:0] LAYER_BOTTOM = 2'd1;
  localparam logic [1:0] LAYER_SIDE   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_SETTLE,
    ST_PICK,
    ST_EMIT
  } state_t;

  // one vertex beat, msb first
  typedef struct packed {
    logic [2:0]        face_code;
    logic [1:0]        layer;
    logic              tex_v;
    logic              tex_u;
    logic signed [5:0] pos_z_half;
    logic signed [5:0] pos_y_half;
    logic signed [5:0] pos_x_half;
  } vertex_t;

  // corner entry {dx, dy, dz, u, v}; an offset bit of 1 means +1 half unit, 0 means -1
  localparam logic [4:0] CORNER_TAB [NUM_FACES][NUM_CORNERS] = '{
    '{5'b10000, 5'b11001, 5'b11111, 5'b11111, 5'b10110, 5'b10000},
    '{5'b00100, 5'b01101, 5'b01011, 5'b01011, 5'b00010, 5'b00100},
    '{5'b01100, 5'b11110, 5'b11011, 5'b11011, 5'b01001, 5'b01100},
    '{5'b00001, 5'b10011, 5'b10110, 5'b10110, 5'b00100, 5'b00001},
    '{5'b00100, 5'b10110, 5'b11111, 5'b11111, 5'b01101, 5'b00100},
    '{5'b10010, 5'b00000, 5'b01001, 5'b01001, 5'b11011, 5'b10010}
  };

endpackage

// ===== rtl/voxel_face_cull_mesher.sv =====
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher: culled voxel mesher over a one-bit occupancy grid
// stores voxel occupancy and emits the triangle vertices of exposed faces
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  in_     | in  | write item (set/clear one voxel) or mesh item (one voxel)
//  out_    | out | one triangle vertex, tlast on the final vertex of a mesh item
//
//  sequence: a write beat is taken in ST_IDLE; a mesh beat is taken, then
//  read by 7 probes of the single occupancy read port, then ST_SETTLE and
//  ST_PICK, then one vertex a cycle while out_tready stays high
//  reset: after rst_n a clearing pass sweeps the 4096-entry occupancy memory
//  one entry a cycle, with in_tready low
//  stalls: out_tready low holds the vertex sequencer; the final vertex sits
//  in the output register while the next input beat is already taken
//
module voxel_face_cull_mesher
  import vfcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // voxel_x[3:0], voxel_y[7:4], voxel_z[11:8], solid[12]
  input  logic        in_tuser,   // operation: 0 write, 1 mesh
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pos_x_half[5:0], pos_y_half[11:6], pos_z_half[17:12],
                                  // tex_u[18], tex_v[19], layer[21:20], face_code[24:22]
  output logic        out_tlast   // last_vertex
);

  // input beat fields
  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic               in_solid;
  logic               in_fire;

  assign in_x     = in_tdata[3:0];
  assign in_y     = in_tdata[7:4];
  assign in_z     = in_tdata[11:8];
  assign in_solid = in_tdata[12];
  assign in_fire  = in_tvalid && in_tready;

  // sequencer state
  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [2:0]         probe_r, probe_nxt;
  logic [2:0]         tag_r, tag_nxt;
  logic               tag_vld_r, tag_vld_nxt;
  logic               edge_r, edge_nxt;
  logic               center_r, center_nxt;
  logic [5:0]         mask_r, mask_nxt;     // exposed faces
  logic [2:0]         face_r, face_nxt;
  logic [2:0]         corner_r, corner_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  vertex_t            out_vert_r, out_vert_nxt;
  logic               out_last_r, out_last_nxt;

  // occupancy memory, one read and one write port
  logic               occ_mem [CELLS];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic               mem_wdata;
  logic               rd_data_r;

  // probe addressing
  logic [2:0]         probe_face;
  logic [COORD_W-1:0] nb_x, nb_y, nb_z;
  logic               probe_edge;

  // emission helpers
  vertex_t            vert;
  logic [5:0]         above_mask;
  logic               vert_last;

  // lowest set face in a mask
  function automatic logic [2:0] low_face(input logic [5:0] m);
    logic [2:0] r;
    r = FACE_PX;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  vfcm_corner u_corner (
    .face   (face_r),
    .corner (corner_r),
    .vox_x  (x_r),
    .vox_y  (y_r),
    .vox_z  (z_r),
    .vert   (vert)
  );

  // probe 0 reads the voxel itself, probes 1..6 read the neighbours
  always_comb begin
    probe_face = probe_r - 3'd1;
    nb_x       = x_r;
    nb_y       = y_r;
    nb_z       = z_r;
    probe_edge = 1'b0;
    if (probe_r != 3'd0) begin
      case (probe_face)
        FACE_PX: begin
          nb_x       = x_r + 4'd1;
          probe_edge = (x_r == X_MAX);
        end
        FACE_NX: begin
          nb_x       = x_r - 4'd1;
          probe_edge = (x_r == '0);
        end
        FACE_PY: begin
          nb_y       = y_r + 4'd1;
          probe_edge = (y_r == Y_MAX);
        end
        FACE_NY: begin
          nb_y       = y_r - 4'd1;
          probe_edge = (y_r == '0);
        end
        FACE_PZ: begin
          nb_z       = z_r + 4'd1;
          probe_edge = (z_r == Z_MAX);
        end
        FACE_NZ: begin
          nb_z       = z_r - 4'd1;
          probe_edge = (z_r == '0);
        end
        default: probe_edge = 1'b0;
      endcase
    end
  end

  // cell index (x*GRID_Y + y)*GRID_Z + z, a plain concatenation on the power-of-two grid
  assign mem_raddr = {nb_x, nb_y, nb_z};

  // faces after the current one that are still to come
  assign above_mask = mask_r & ~((6'd2 << face_r) - 6'd1);
  assign vert_last  = (corner_r == CORNER_LAST) && (above_mask == 6'd0);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    probe_nxt     = probe_r;
    tag_nxt       = probe_r;
    tag_vld_nxt   = 1'b0;
    edge_nxt      = probe_edge;
    center_nxt    = center_r;
    mask_nxt      = mask_r;
    face_nxt      = face_r;
    corner_nxt    = corner_r;
    out_valid_nxt = out_valid_r;
    out_vert_nxt  = out_vert_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = {in_x, in_y, in_z};
    mem_wdata     = in_solid;
    in_tready     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // read data returns in the cycle after its probe
    if (tag_vld_r) begin
      if (tag_r == 3'd0) begin
        center_nxt = rd_data_r;
      end else begin
        mask_nxt[tag_r - 3'd1] = edge_r || !rd_data_r;
      end
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = 1'b0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          x_nxt = in_x;
          y_nxt = in_y;
          z_nxt = in_z;
          if (in_tuser == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            probe_nxt = 3'd0;
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        tag_vld_nxt = 1'b1;
        if (probe_r == PROBE_LAST) begin
          state_nxt = ST_SETTLE;
        end else begin
          probe_nxt = probe_r + 3'd1;
        end
      end
      ST_SETTLE: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (!center_r || mask_r == 6'd0) begin
          state_nxt = ST_IDLE;
        end else begin
          face_nxt   = low_face(mask_r);
          corner_nxt = 3'd0;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_vert_nxt  = vert;
          out_last_nxt  = vert_last;
          if (corner_r == CORNER_LAST) begin
            if (vert_last) begin
              state_nxt = ST_IDLE;
            end else begin
              face_nxt   = low_face(above_mask);
              corner_nxt = 3'd0;
            end
          end else begin
            corner_nxt = corner_r + 3'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      probe_r     <= '0;
      tag_vld_r   <= 1'b0;
      face_r      <= FACE_PX;
      corner_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      probe_r     <= probe_nxt;
      tag_vld_r   <= tag_vld_nxt;
      face_r      <= face_nxt;
      corner_r    <= corner_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    tag_r      <= tag_nxt;
    edge_r     <= edge_nxt;
    center_r   <= center_nxt;
    mask_r     <= mask_nxt;
    out_vert_r <= out_vert_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= occ_mem[mem_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_vert_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("input taken during clearing pass");

  a_mesh_starts_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == OP_MESH) |=> (state_r == ST_PROBE && probe_r == 3'd0))
    else $error("mesh beat did not start probing");

  a_emit_exposed_face: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (mask_r[face_r] && center_r))
    else $error("emitting a hidden face or an air voxel");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (probe_r <= PROBE_LAST))
    else $error("probe counter out of range");
`endif

endmodule

// ===== rtl/vfcm_corner.sv =====
// ----------------------------------------------------------------------------
// vfcm_corner: vertex builder
// turns a face, a corner and the voxel coordinates into one vertex beat
// ----------------------------------------------------------------------------
module vfcm_corner
  import vfcm_pkg::*;
(
  input  logic [2:0]         face,
  input  logic [2:0]         corner,
  input  logic [COORD_W-1:0] vox_x,
  input  logic [COORD_W-1:0] vox_y,
  input  logic [COORD_W-1:0] vox_z,
  output vertex_t            vert
);

  logic [4:0] entry;

  // 2*c plus or minus one in half units
  function automatic logic signed [5:0] half_pos(input logic [COORD_W-1:0] c,
                                                 input logic up);
    logic [5:0] base;
    base = {1'b0, c, 1'b0};
    return $signed(base + (up ? 6'd1 : 6'h3F));
  endfunction

  always_comb begin
    entry = 5'd0;
    if (face <= FACE_NZ && corner <= CORNER_LAST) begin
      entry = CORNER_TAB[face][corner];
    end
    vert.face_code  = face;
    vert.tex_u      = entry[1];
    vert.tex_v      = entry[0];
    vert.pos_x_half = half_pos(vox_x, entry[4]);
    vert.pos_y_half = half_pos(vox_y, entry[3]);
    vert.pos_z_half = half_pos(vox_z, entry[2]);
    unique case (face)
      FACE_PY: vert.layer = LAYER_TOP;
      FACE_NY: vert.layer = LAYER_BOTTOM;
      default: vert.layer = LAYER_SIDE;
    endcase
  end

endmodule
